@@ hw/rtl/llit_pkg.sv @@
`timescale 1ns / 1ps

package llit_pkg;

   // Operand slice width of the partial-product multipliers.
   localparam int MUL_CHUNK_BITS = 24;

   // Tolerance register format and reset value.
   localparam int TOL_WIDTH = 12;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 12'd4;

   // Stage enables of a two-stage multiplier.
   typedef struct packed {
      logic s1;
      logic s2;
   } mul_en_type;

endpackage

@@ hw/rtl/llit_mul.sv @@
`timescale 1ns / 1ps

module llit_mul import llit_pkg::*; #(
   parameter int WA = 48,
   parameter int WB = 48
) (
   input  logic              clock,
   input  mul_en_type        en,
   input  logic [WA-1:0]     a,
   input  logic [WB-1:0]     b,
   output logic [WA+WB-1:0]  p
);

   localparam int NA = (WA + MUL_CHUNK_BITS - 1) / MUL_CHUNK_BITS;
   localparam int NB = (WB + MUL_CHUNK_BITS - 1) / MUL_CHUNK_BITS;
   localparam int PA = NA * MUL_CHUNK_BITS;
   localparam int PB = NB * MUL_CHUNK_BITS;
   localparam int PW = PA + PB;

   logic [PA-1:0] a_pad;
   logic [PB-1:0] b_pad;
   logic [2*MUL_CHUNK_BITS-1:0] pp_ff [NA*NB];
   logic [PW-1:0] acc;
   logic [WA+WB-1:0] p_ff;

   assign a_pad = PA'(a);
   assign b_pad = PB'(b);

   // First stage: every slice pair is multiplied and registered.
   always_ff @(posedge clock) begin
      if (en.s1) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i*NB+j] <= a_pad[i*MUL_CHUNK_BITS +: MUL_CHUNK_BITS]
                              * b_pad[j*MUL_CHUNK_BITS +: MUL_CHUNK_BITS];
            end
         end
      end
   end

   // Second stage: the shifted partial products are summed.
   always_comb begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (PW'(pp_ff[i*NB+j]) << ((i + j) * MUL_CHUNK_BITS));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         p_ff <= acc[WA+WB-1:0];
      end
   end

   assign p = p_ff;

endmodule

@@ hw/rtl/line_line_intersection_test.sv @@
`timescale 1ns / 1ps

// Closest-point test of two infinite 3D lines. One line pair is taken per clock
// cycle while req_stall is low. The datapath has ten register stages, and the
// first of them loads at the edge that accepts the request. The wide products
// are built from registered 24x24 partial products, over two stages each. The
// pipeline closes bubbles, so a stalled result holds back only the stages that
// are full. Lines with a zero cross product report parallel and never meet. The
// tolerance register is to be written through the csr_ channel only while no
// request is in flight; the block itself does not enforce this. That channel
// is always ready.
module line_line_intersection_test import llit_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_first_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_origin_z,
   input  logic signed [COORD_WIDTH-1:0] req_first_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_dir_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_dir_z,
   input  logic signed [COORD_WIDTH-1:0] req_second_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_origin_z,
   input  logic signed [COORD_WIDTH-1:0] req_second_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_dir_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_dir_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_lines_meet,
   output logic                          rsp_lines_parallel,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [TOL_WIDTH-1:0]          csr_data
);

   localparam int W  = COORD_WIDTH;
   localparam int PW = 2 * W;          // direction product
   localparam int CW = 2 * W + 1;      // cross product, signed
   localparam int CM = 2 * W;          // cross product magnitude
   localparam int EW = W + 1;          // origin difference, signed
   localparam int QW = 4 * W;          // squared cross component
   localparam int XW = EW + CM;        // origin difference times cross component
   localparam int DW = 4 * W + 2;      // denominator
   localparam int SW = 3 * W + 4;      // signed projection
   localparam int SM = 3 * W + 3;      // projection magnitude
   localparam int GW = SM + CM;        // gap
   localparam int LW = DW + TOL_WIDTH; // limit
   localparam int KW = (GW > LW) ? GW : LW;

   // Tolerance register.
   logic [TOL_WIDTH-1:0] tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   // Pipeline control: a stage loads when it is empty or its successor loads.
   logic [10:1] rdy;
   logic [9:1]  v_ff;
   logic        rsp_valid_ff;

   always_comb begin
      rdy[10] = !rsp_valid_ff || !rsp_stall;
      for (int k = 9; k >= 1; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign req_stall = !rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy[1]) begin
            v_ff[1] <= req_valid;
         end
         for (int k = 2; k <= 9; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         if (rdy[10]) begin
            rsp_valid_ff <= v_ff[9];
         end
      end
   end

   // Stage 1: direction products and origin differences.
   logic signed [PW-1:0] s1_p_ff [6];
   logic signed [EW-1:0] s1_e_ff [3];

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_p_ff[0] <= req_first_dir_y * req_second_dir_z;
         s1_p_ff[1] <= req_first_dir_z * req_second_dir_y;
         s1_p_ff[2] <= req_first_dir_z * req_second_dir_x;
         s1_p_ff[3] <= req_first_dir_x * req_second_dir_z;
         s1_p_ff[4] <= req_first_dir_x * req_second_dir_y;
         s1_p_ff[5] <= req_first_dir_y * req_second_dir_x;
         s1_e_ff[0] <= EW'(req_second_origin_x) - EW'(req_first_origin_x);
         s1_e_ff[1] <= EW'(req_second_origin_y) - EW'(req_first_origin_y);
         s1_e_ff[2] <= EW'(req_second_origin_z) - EW'(req_first_origin_z);
      end
   end

   // Stage 2: cross product components.
   logic signed [CW-1:0] s2_c_ff [3];
   logic signed [EW-1:0] s2_e_ff [3];

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         for (int i = 0; i < 3; i++) begin
            s2_c_ff[i] <= CW'(s1_p_ff[2*i]) - CW'(s1_p_ff[2*i+1]);
            s2_e_ff[i] <= s1_e_ff[i];
         end
      end
   end

   // Stage 3: sign and magnitude split for the wide multipliers.
   logic [CM-1:0] s3_cmag_ff [3];
   logic [EW-1:0] s3_emag_ff [3];
   logic [2:0]    s3_neg_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         for (int i = 0; i < 3; i++) begin
            s3_cmag_ff[i] <= s2_c_ff[i][CW-1] ? CM'(-s2_c_ff[i]) : CM'(s2_c_ff[i]);
            s3_emag_ff[i] <= s2_e_ff[i][EW-1] ? EW'(-s2_e_ff[i]) : EW'(s2_e_ff[i]);
            s3_neg_ff[i]  <= s2_c_ff[i][CW-1] ^ s2_e_ff[i][EW-1];
         end
      end
   end

   // Stages 4 and 5: squared components and projection terms.
   mul_en_type   en_a;
   logic [QW-1:0] csq [3];
   logic [XW-1:0] ec [3];
   logic [CM-1:0] s4_cmag_ff [3];
   logic [CM-1:0] s5_cmag_ff [3];
   logic [2:0]    s4_neg_ff;
   logic [2:0]    s5_neg_ff;

   assign en_a.s1 = rdy[4];
   assign en_a.s2 = rdy[5];

   for (genvar g = 0; g < 3; g++) begin : g_first_mul
      llit_mul #(.WA(CM), .WB(CM)) u_csq (
         .clock (clock),
         .en    (en_a),
         .a     (s3_cmag_ff[g]),
         .b     (s3_cmag_ff[g]),
         .p     (csq[g])
      );
      llit_mul #(.WA(EW), .WB(CM)) u_ec (
         .clock (clock),
         .en    (en_a),
         .a     (s3_emag_ff[g]),
         .b     (s3_cmag_ff[g]),
         .p     (ec[g])
      );
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_cmag_ff <= s3_cmag_ff;
         s4_neg_ff  <= s3_neg_ff;
      end
      if (rdy[5]) begin
         s5_cmag_ff <= s4_cmag_ff;
         s5_neg_ff  <= s4_neg_ff;
      end
   end

   // Stage 6: denominator and signed projection.
   logic [DW-1:0]        s6_den_ff;
   logic signed [SW-1:0] s6_s_ff;
   logic [CM-1:0]        s6_cmag_ff [3];
   logic signed [SW-1:0] term [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         term[i] = s5_neg_ff[i] ? -SW'(ec[i]) : SW'(ec[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         s6_den_ff  <= DW'(csq[0]) + DW'(csq[1]) + DW'(csq[2]);
         s6_s_ff    <= term[0] + term[1] + term[2];
         s6_cmag_ff <= s5_cmag_ff;
      end
   end

   // Stage 7: projection magnitude and the parallel flag.
   logic [SM-1:0] s7_abs_s_ff;
   logic [DW-1:0] s7_den_ff;
   logic          s7_par_ff;
   logic [CM-1:0] s7_cmag_ff [3];

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         s7_abs_s_ff <= s6_s_ff[SW-1] ? SM'(-s6_s_ff) : SM'(s6_s_ff);
         s7_den_ff   <= s6_den_ff;
         s7_par_ff   <= (s6_den_ff == '0);
         s7_cmag_ff  <= s6_cmag_ff;
      end
   end

   // Stages 8 and 9: per-axis gaps and the tolerance limit.
   mul_en_type    en_b;
   logic [GW-1:0] gap [3];
   logic [LW-1:0] lim;
   logic          s8_par_ff;
   logic          s9_par_ff;

   assign en_b.s1 = rdy[8];
   assign en_b.s2 = rdy[9];

   for (genvar g = 0; g < 3; g++) begin : g_gap_mul
      llit_mul #(.WA(SM), .WB(CM)) u_gap (
         .clock (clock),
         .en    (en_b),
         .a     (s7_abs_s_ff),
         .b     (s7_cmag_ff[g]),
         .p     (gap[g])
      );
   end

   llit_mul #(.WA(DW), .WB(TOL_WIDTH)) u_lim (
      .clock (clock),
      .en    (en_b),
      .a     (s7_den_ff),
      .b     (tol_ff),
      .p     (lim)
   );

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         s8_par_ff <= s7_par_ff;
      end
      if (rdy[9]) begin
         s9_par_ff <= s8_par_ff;
      end
   end

   // Stage 10: per-axis compare into the result register.
   logic [2:0] close;
   logic       meet_ff;
   logic       par_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         close[i] = KW'(gap[i]) < KW'(lim);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[10]) begin
         meet_ff <= !s9_par_ff && (&close);
         par_ff  <= s9_par_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_lines_meet     = meet_ff;
   assign rsp_lines_parallel = par_ff;

   // Checks on the pipeline control and the result.
   a_par_no_meet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(meet_ff && par_ff))
      else $error("parallel result reports a hit");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && (v_ff == '0))
      else $error("pipeline not empty after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v_ff[1])
      else $error("accepted request did not enter the pipeline");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&v_ff) && rsp_valid_ff && rsp_stall))
      else $error("request stalled while the pipeline has room");

endmodule
